// ===== sv/ascon_mac_pkg.sv =====
// ----------------------------------------------------------------------------
// ascon_mac_pkg
// Shared types, constants and functions of the keyed sponge MAC: transfer
// payloads, the round function, and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ascon_mac_pkg;

    // Domain word that opens every message.
    localparam logic [63:0] DOMAIN_WORD = 64'h54554e544f4d4d41;
    // Pad byte placed after the message bytes.
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    // Last round index; a round loop ends after this round.
    localparam logic [3:0]  RC_LAST     = 4'd11;
    // Start index for the 8-round block permutation.
    localparam logic [3:0]  RC_START_8  = 4'd4;
    // Start index for the 12-round permutation.
    localparam logic [3:0]  RC_START_12 = 4'd0;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_LINK_ID  = 2'd2;

    // Microcode step addresses used as jump targets.
    localparam logic [3:0] STEP_WAIT    = 4'd0;
    localparam logic [3:0] STEP_BRANCH  = 4'd4;
    localparam logic [3:0] STEP_PARTIAL = 4'd9;
    localparam logic [3:0] STEP_FINAL   = 4'd10;

    typedef logic [4:0][63:0] sponge_t;

    typedef struct packed {
        logic [63:0] block;
        logic [3:0]  byte_count;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } out_item_t;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [15:0] link_id;
    } cfg_t;

    // Datapath operations, one per microcode step.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INIT,
        OP_ROUND,
        OP_KEY34,
        OP_ABSORB,
        OP_PAD_FULL,
        OP_ABSORB_PART,
        OP_FIN_PREP
    } dp_op_t;

    // Sequencer jump conditions.
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_WAIT,
        JC_LOOP,
        JC_PART,
        JC_NOT_LAST,
        JC_ALWAYS,
        JC_EMIT
    } jump_t;

    typedef struct packed {
        dp_op_t     op;
        jump_t      jc;
        logic [3:0] target;
        logic       rc_load;
        logic [3:0] rc_start;
    } ctrl_word_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        dp_op_t     op;
        logic       capture;
        logic [3:0] rc;
    } dp_ctrl_t;

    // Status of the captured item, back to the sequencer.
    typedef struct packed {
        logic last;
        logic full;
    } dp_status_t;

    function automatic logic [63:0] ror64(input logic [63:0] v, input int s);
        return (v >> s) | (v << (64 - s));
    endfunction

    // Round constant: high nibble counts down from 15, low nibble counts up.
    function automatic logic [7:0] round_const(input logic [3:0] r);
        return {4'hf - r, r};
    endfunction

    // One round of the 320-bit permutation.
    function automatic sponge_t perm_round(input sponge_t s, input logic [3:0] r);
        logic [63:0] x0, x1, x2, x3, x4;
        logic [63:0] t0, t1, t2, t3, t4;
        sponge_t     res;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {56'd0, round_const(r)};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        res[0] = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
        res[1] = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
        res[2] = x2 ^ ror64(x2, 1)  ^ ror64(x2, 6);
        res[3] = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
        res[4] = x4 ^ ror64(x4, 7)  ^ ror64(x4, 41);
        return res;
    endfunction

    // Microcode program. Fields: op, jump, target, rc_load, rc_start.
    function automatic ctrl_word_t ucode_rom(input logic [3:0] pc);
        ctrl_word_t cw;
        case (pc)
            4'd0:  cw = '{OP_NOP,         JC_WAIT,     STEP_BRANCH,  1'b0, RC_START_12};
            4'd1:  cw = '{OP_INIT,        JC_NEXT,     STEP_WAIT,    1'b1, RC_START_12};
            4'd2:  cw = '{OP_ROUND,       JC_LOOP,     STEP_WAIT,    1'b0, RC_START_12};
            4'd3:  cw = '{OP_KEY34,       JC_NEXT,     STEP_WAIT,    1'b0, RC_START_12};
            4'd4:  cw = '{OP_NOP,         JC_PART,     STEP_PARTIAL, 1'b0, RC_START_12};
            4'd5:  cw = '{OP_ABSORB,      JC_NEXT,     STEP_WAIT,    1'b1, RC_START_8};
            4'd6:  cw = '{OP_ROUND,       JC_LOOP,     STEP_WAIT,    1'b0, RC_START_8};
            4'd7:  cw = '{OP_NOP,         JC_NOT_LAST, STEP_WAIT,    1'b0, RC_START_12};
            4'd8:  cw = '{OP_PAD_FULL,    JC_ALWAYS,   STEP_FINAL,   1'b0, RC_START_12};
            4'd9:  cw = '{OP_ABSORB_PART, JC_NEXT,     STEP_WAIT,    1'b0, RC_START_12};
            4'd10: cw = '{OP_FIN_PREP,    JC_NEXT,     STEP_WAIT,    1'b1, RC_START_12};
            4'd11: cw = '{OP_ROUND,       JC_LOOP,     STEP_WAIT,    1'b0, RC_START_12};
            4'd12: cw = '{OP_KEY34,       JC_NEXT,     STEP_WAIT,    1'b0, RC_START_12};
            4'd13: cw = '{OP_NOP,         JC_EMIT,     STEP_WAIT,    1'b0, RC_START_12};
            default: cw = '{OP_NOP,       JC_ALWAYS,   STEP_WAIT,    1'b0, RC_START_12};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ascon_keyed_sponge_mac_top.sv =====
// ----------------------------------------------------------------------------
// ascon_keyed_sponge_mac_top
// Keyed sponge MAC over the 320-bit permutation, run by a microcoded
// sequencer that issues one round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Load key_high, key_low and link_id through the cfg_* write channel
//   while the block is idle. Stream each message on the s_* channel as 64-bit
//   big-endian blocks; mark the final block with last and give its valid
//   bytes in byte_count. One 128-bit tag transfer appears on the m_* channel
//   for every final block; other blocks produce no transfer.
// Step sequence:
//   A middle block runs the absorb step and eight rounds plus sequencing;
//   a first block adds initialization, twelve rounds and a key step. A
//   final block under eight bytes is absorbed with its pad, a full one is
//   absorbed, run for eight rounds and padded; finalization, twelve rounds
//   and a key step fill the tag register. Blocks enter only at the wait step.
// Reset and stalls:
//   Reset clears the sequencer and configuration registers to zero, closes
//   any open message and drops m_valid. The tag sits in an output register,
//   so the next message may start while it waits; a second tag waits in
//   the sequencer until the first one has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon_keyed_sponge_mac_top
    import ascon_mac_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    cfg_t       cfg_reg;
    logic [3:0] pc_reg;
    logic [3:0] pc_next;
    logic [3:0] rc_reg;
    logic       msg_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;
    ctrl_word_t cw;
    dp_ctrl_t   ctrl;
    dp_status_t status;
    logic [63:0] word3;
    logic [63:0] word4;
    logic       accept;
    logic       emit_ok;

    // Current control word.
    assign cw      = ucode_rom(pc_reg);
    assign s_ready = (cw.jc == JC_WAIT);
    assign accept  = s_valid && s_ready;
    assign emit_ok = (cw.jc == JC_EMIT) && (!m_valid_reg || m_ready);

    assign cfg_ready = 1'b1;

    assign ctrl.op      = cw.op;
    assign ctrl.capture = accept;
    assign ctrl.rc      = rc_reg;

    // Step counter with conditional jumps.
    always_comb begin
        case (cw.jc)
            JC_NEXT:     pc_next = pc_reg + 4'd1;
            JC_WAIT:     pc_next = !accept ? pc_reg :
                                   (msg_reg ? cw.target : pc_reg + 4'd1);
            JC_LOOP:     pc_next = (rc_reg == RC_LAST) ? pc_reg + 4'd1 : pc_reg;
            JC_PART:     pc_next = (status.last && !status.full) ? cw.target
                                                                 : pc_reg + 4'd1;
            JC_NOT_LAST: pc_next = !status.last ? cw.target : pc_reg + 4'd1;
            JC_ALWAYS:   pc_next = cw.target;
            JC_EMIT:     pc_next = emit_ok ? cw.target : pc_reg;
            default:     pc_next = STEP_WAIT;
        endcase
    end

    // Sequencer, configuration and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= STEP_WAIT;
            rc_reg      <= '0;
            msg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            cfg_reg     <= '0;
        end else begin
            pc_reg <= pc_next;

            if (cw.rc_load) begin
                rc_reg <= cw.rc_start;
            end else if (cw.op == OP_ROUND) begin
                rc_reg <= rc_reg + 4'd1;
            end

            // A message stays open from its first block to its tag.
            if (accept) begin
                msg_reg <= 1'b1;
            end else if (emit_ok) begin
                msg_reg <= 1'b0;
            end

            if (emit_ok) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_HIGH: cfg_reg.key_high <= cfg_data;
                    REG_KEY_LOW:  cfg_reg.key_low  <= cfg_data;
                    REG_LINK_ID:  cfg_reg.link_id  <= cfg_data[15:0];
                    default:      cfg_reg          <= cfg_reg;
                endcase
            end
        end
    end

    // Tag register.
    always_ff @(posedge aclk) begin
        if (emit_ok) begin
            m_data_reg.tag_high <= word3;
            m_data_reg.tag_low  <= word4;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ascon_mac_datapath u_datapath (
        .aclk   (aclk),
        .item   (s_data),
        .cfg    (cfg_reg),
        .ctrl   (ctrl),
        .status (status),
        .word3  (word3),
        .word4  (word4)
    );

endmodule

`default_nettype wire

// ===== sv/ascon_mac_datapath.sv =====
// ----------------------------------------------------------------------------
// ascon_mac_datapath
// Sponge state register with its round unit, the captured input item and
// the key and pad injections selected by the microcode operation.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon_mac_datapath
    import ascon_mac_pkg::*;
(
    input  wire logic       aclk,
    input  wire in_item_t   item,
    input  wire cfg_t       cfg,
    input  wire dp_ctrl_t   ctrl,
    output dp_status_t      status,
    output logic [63:0]     word3,
    output logic [63:0]     word4
);

    sponge_t     state_reg;
    sponge_t     state_next;
    in_item_t    item_reg;
    logic [63:0] partial_word;
    logic [2:0]  count;

    // Message bytes below the count, then the pad byte, then zeros.
    assign count = item_reg.byte_count[2:0];

    always_comb begin
        partial_word = '0;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < count) begin
                partial_word[63 - 8*i -: 8] = item_reg.block[63 - 8*i -: 8];
            end else if (3'(i) == count) begin
                partial_word[63 - 8*i -: 8] = PAD_BYTE;
            end
        end
    end

    // Next sponge state for the current operation.
    always_comb begin
        state_next = state_reg;
        case (ctrl.op)
            OP_INIT: begin
                state_next[0] = DOMAIN_WORD;
                state_next[1] = cfg.key_high;
                state_next[2] = cfg.key_low;
                state_next[3] = {48'd0, cfg.link_id};
                state_next[4] = ~{48'd0, cfg.link_id};
            end
            OP_ROUND: begin
                state_next = perm_round(state_reg, ctrl.rc);
            end
            OP_KEY34: begin
                state_next[3] = state_reg[3] ^ cfg.key_high;
                state_next[4] = state_reg[4] ^ cfg.key_low;
            end
            OP_ABSORB: begin
                state_next[0] = state_reg[0] ^ item_reg.block;
            end
            OP_PAD_FULL: begin
                state_next[0] = state_reg[0] ^ {PAD_BYTE, 56'd0};
            end
            OP_ABSORB_PART: begin
                state_next[0] = state_reg[0] ^ partial_word;
            end
            OP_FIN_PREP: begin
                state_next[1] = state_reg[1] ^ cfg.key_high;
                state_next[2] = state_reg[2] ^ cfg.key_low;
                state_next[4] = state_reg[4] ^ 64'd1;
            end
            default: begin
                state_next = state_reg;
            end
        endcase
    end

    // Payload registers; every message begins with a full initialization.
    always_ff @(posedge aclk) begin
        state_reg <= state_next;
        if (ctrl.capture) begin
            item_reg <= item;
        end
    end

    // A count of eight or more makes a full block.
    assign status.last = item_reg.last;
    assign status.full = item_reg.byte_count[3];
    assign word3       = state_reg[3];
    assign word4       = state_reg[4];

endmodule

`default_nettype wire

// ===== tb/tb_ascon_keyed_sponge_mac_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascon_keyed_sponge_mac_top
// Self-checking bench for the keyed sponge MAC. Messages stream in as 64-bit
// blocks while a software model of the sponge predicts every 128-bit tag.
// Directed tests cover the byte counts, full and empty final blocks and key
// changes inside a message. Random traffic then runs under several key
// settings, with random stalls on both channels in all but one phase.
// ----------------------------------------------------------------------------

module tb_ascon_keyed_sponge_mac_top
    import ascon_mac_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          DRAIN_CYCLES  = 64;
    localparam int          RANDOM_BLOCKS = 1900;
    localparam int          PHASE_COUNT   = 10;
    localparam logic [63:0] MAC_DOMAIN    = 64'h54554e544f4d4d41;
    // Round constants of rounds 0 to 11, first round in the top byte.
    localparam logic [95:0] ROUND_CONST   = 96'hf0e1d2c3b4a5968778695a4b;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;

    // Model state: sponge words, open-message flag and the key registers.
    logic [63:0] sponge [5];
    bit          msg_open = 1'b0;
    logic [63:0] key_hi   = '0;
    logic [63:0] key_lo   = '0;
    logic [15:0] tid_reg  = '0;

    out_item_t   expected_tags [$];
    out_item_t   want_tag;
    int          mismatch_count = 0;
    int          blocks_sent    = 0;
    int unsigned cycle_count    = 0;
    bit          quiet          = 1'b0;

    ascon_keyed_sponge_mac_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
        return (v >> n) | (v << (64 - n));
    endfunction

    // Runs the last nrounds rounds of the permutation on the model sponge.
    function automatic void permute(input int unsigned nrounds);
        logic [63:0] a0, a1, a2, a3, a4;
        logic [63:0] n0, n1, n2, n3, n4;
        for (int unsigned r = 12 - nrounds; r < 12; r++) begin
            a0 = sponge[0];
            a1 = sponge[1];
            a2 = sponge[2] ^ {56'd0, ROUND_CONST[95 - 8 * r -: 8]};
            a3 = sponge[3];
            a4 = sponge[4];
            a0 ^= a4;
            a4 ^= a3;
            a2 ^= a1;
            n0 = ~a0 & a1;
            n1 = ~a1 & a2;
            n2 = ~a2 & a3;
            n3 = ~a3 & a4;
            n4 = ~a4 & a0;
            a0 ^= n1;
            a1 ^= n2;
            a2 ^= n3;
            a3 ^= n4;
            a4 ^= n0;
            a1 ^= a0;
            a0 ^= a4;
            a3 ^= a2;
            a2 = ~a2;
            sponge[0] = a0 ^ rotr(a0, 19) ^ rotr(a0, 28);
            sponge[1] = a1 ^ rotr(a1, 61) ^ rotr(a1, 39);
            sponge[2] = a2 ^ rotr(a2, 1) ^ rotr(a2, 6);
            sponge[3] = a3 ^ rotr(a3, 10) ^ rotr(a3, 17);
            sponge[4] = a4 ^ rotr(a4, 7) ^ rotr(a4, 41);
        end
    endfunction

    // Advances the model by one accepted block and queues the tag it yields.
    function automatic void predict_mac(input in_item_t it);
        logic [3:0]  n;
        logic [63:0] keep;
        out_item_t   tag;
        if (!msg_open) begin
            sponge[0] = MAC_DOMAIN;
            sponge[1] = key_hi;
            sponge[2] = key_lo;
            sponge[3] = {48'd0, tid_reg};
            sponge[4] = ~{48'd0, tid_reg};
            permute(12);
            sponge[3] ^= key_hi;
            sponge[4] ^= key_lo;
            msg_open = 1'b1;
        end
        if (!it.last) begin
            sponge[0] ^= it.block;
            permute(8);
            return;
        end
        n = (it.byte_count > 4'd8) ? 4'd8 : it.byte_count;
        if (n == 4'd8) begin
            // A full final block is absorbed whole, then a pad-only block.
            sponge[0] ^= it.block;
            permute(8);
            sponge[0] ^= {8'h80, 56'd0};
        end else begin
            keep = (n == 4'd0) ? 64'd0 : (~64'd0 << (64 - 8 * n));
            sponge[0] ^= (it.block & keep) | ({56'd0, 8'h80} << (56 - 8 * n));
        end
        sponge[4] ^= 64'd1;
        sponge[1] ^= key_hi;
        sponge[2] ^= key_lo;
        permute(12);
        sponge[3] ^= key_hi;
        sponge[4] ^= key_lo;
        tag.tag_high = sponge[3];
        tag.tag_low  = sponge[4];
        expected_tags.push_back(tag);
        msg_open = 1'b0;
    endfunction

    // Tag receiver with random back-pressure; compares every transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tags.size() == 0) begin
                    $display("%0t: unexpected tag, actual %h", $time, m_data);
                    mismatch_count++;
                end else begin
                    want_tag = expected_tags.pop_front();
                    if (m_data.tag_high !== want_tag.tag_high) begin
                        $display("%0t: tag_high expected %h actual %h",
                                 $time, want_tag.tag_high, m_data.tag_high);
                        mismatch_count++;
                    end
                    if (m_data.tag_low !== want_tag.tag_low) begin
                        $display("%0t: tag_low expected %h actual %h",
                                 $time, want_tag.tag_low, m_data.tag_low);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= quiet || ($urandom_range(0, 99) >= 33);
        end
    end

    // Holds one register write until its transfer completes.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Writes all three registers; the link id write carries junk above bit 15.
    task automatic load_config(input logic [63:0] kh, input logic [63:0] kl,
                               input logic [15:0] tid);
        logic [47:0] junk;
        junk = 48'({$urandom, $urandom});
        write_reg(REG_KEY_HIGH, kh);
        write_reg(REG_KEY_LOW, kl);
        write_reg(REG_LINK_ID, {junk, tid});
        cfg_valid <= 1'b0;
        key_hi  = kh;
        key_lo  = kl;
        tid_reg = tid;
    endtask

    // Sends one block, with an optional random gap before it.
    task automatic send_block(input logic [63:0] blk, input logic [3:0] cnt,
                              input logic lst);
        in_item_t it;
        it.block      = blk;
        it.byte_count = cnt;
        it.last       = lst;
        if (!quiet && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_mac(it);
        blocks_sent++;
    endtask

    // Lets every expected tag arrive and the sequencer settle before a write.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_tags.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return 64'd0;
            1:       return ~64'd0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic load_random_config();
        logic [63:0] t;
        t = pick_word();
        load_config(pick_word(), pick_word(), t[15:0]);
    endtask

    function automatic logic [3:0] pick_last_count();
        if ($urandom_range(0, 9) == 0)
            return 4'($urandom_range(9, 15));
        return 4'($urandom_range(0, 8));
    endfunction

    // Empty message under the reset register values.
    task automatic test_reset_config();
        send_block(64'd0, 4'd0, 1'b1);
        drain();
    endtask

    // Single-block messages with byte counts 0 to 9 and 15; stray bytes set to ones up to count 8.
    task automatic test_last_byte_counts();
        load_config(~64'd0, ~64'd0, 16'hffff);
        for (int c = 0; c <= 8; c++)
            send_block(~64'd0, 4'(c), 1'b1);
        send_block({$urandom, $urandom}, 4'd9, 1'b1);
        send_block({$urandom, $urandom}, 4'd15, 1'b1);
        drain();
    endtask

    // Middle blocks ignore byte_count; the message ends on a full block.
    task automatic test_multi_block();
        load_config(~64'd0, 64'd0, 16'h0000);
        send_block(64'd0, 4'd0, 1'b0);
        send_block(~64'd0, 4'd15, 1'b0);
        send_block(64'd0, 4'd8, 1'b1);
        drain();
    endtask

    // Keys change between the first and the last block of one message.
    task automatic test_config_mid_message();
        load_config(64'h0123456789abcdef, 64'hfedcba9876543210, 16'h5a5a);
        send_block({$urandom, $urandom}, 4'd3, 1'b0);
        drain();
        load_config(64'h8000000000000001, 64'h7ffffffffffffffe, 16'ha5a5);
        send_block({$urandom, $urandom}, 4'd5, 1'b1);
        drain();
    endtask

    // Random messages under changing keys; one phase runs without stalls.
    task automatic test_random_traffic();
        int quota;
        int nblk;
        int sel;
        bit switch_keys;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            quiet = (phase == 4);
            load_random_config();
            quota = blocks_sent + RANDOM_BLOCKS / PHASE_COUNT;
            while (blocks_sent < quota) begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    nblk = $urandom_range(1, 3);
                else if (sel < 95)
                    nblk = $urandom_range(4, 8);
                else
                    nblk = $urandom_range(9, 24);
                // Now and then the keys are swapped after the first block.
                switch_keys = (nblk > 1) && ($urandom_range(0, 29) == 0);
                for (int i = 0; i < nblk - 1; i++) begin
                    send_block({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
                    if (switch_keys && i == 0) begin
                        drain();
                        load_random_config();
                    end
                end
                send_block({$urandom, $urandom}, pick_last_count(), 1'b1);
            end
            drain();
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_config();
        test_last_byte_counts();
        test_multi_block();
        test_config_mid_message();
        test_random_traffic();
        drain();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
